/* hdl/tesd_pkg.sv */
package tesd_pkg;

  // sequence phase after ESC
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CSI,
    PH_SS3,
    PH_MACT,
    PH_MCOL,
    PH_MROW
  } phase_t;

  // event kinds
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_KEY   = 2'd1;
  localparam logic [1:0] EV_MOUSE = 2'd2;

  // key codes
  localparam logic [4:0] KEY_CHAR   = 5'd0;
  localparam logic [4:0] KEY_UP     = 5'd1;
  localparam logic [4:0] KEY_DOWN   = 5'd2;
  localparam logic [4:0] KEY_RIGHT  = 5'd3;
  localparam logic [4:0] KEY_LEFT   = 5'd4;
  localparam logic [4:0] KEY_HOME   = 5'd5;
  localparam logic [4:0] KEY_END    = 5'd6;
  localparam logic [4:0] KEY_INSERT = 5'd7;
  localparam logic [4:0] KEY_DELETE = 5'd8;
  localparam logic [4:0] KEY_PGUP   = 5'd9;
  localparam logic [4:0] KEY_PGDN   = 5'd10;
  localparam logic [4:0] KEY_F1     = 5'd11;
  localparam logic [4:0] KEY_F2     = 5'd12;
  localparam logic [4:0] KEY_F3     = 5'd13;
  localparam logic [4:0] KEY_F4     = 5'd14;
  localparam logic [4:0] KEY_F5     = 5'd15;
  localparam logic [4:0] KEY_F6     = 5'd16;
  localparam logic [4:0] KEY_F7     = 5'd17;
  localparam logic [4:0] KEY_F8     = 5'd18;
  localparam logic [4:0] KEY_F9     = 5'd19;
  localparam logic [4:0] KEY_F10    = 5'd20;
  localparam logic [4:0] KEY_F11    = 5'd21;
  localparam logic [4:0] KEY_F12    = 5'd22;

  // mouse buttons
  localparam logic [2:0] BTN_SCROLL_UP = 3'd4;
  localparam logic [2:0] BTN_SCROLL_DN = 3'd5;
  localparam logic [2:0] BTN_MOVE      = 3'd6;

  // byte values
  localparam logic [7:0] CH_CSI      = 8'h5B;  // '['
  localparam logic [7:0] CH_SS3      = 8'h4F;  // 'O'
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_MOUSE    = 8'h4D;  // 'M'
  localparam logic [7:0] CH_HOME     = 8'h48;  // 'H'
  localparam logic [7:0] CH_END      = 8'h46;  // 'F'
  localparam logic [7:0] CH_ARROW_UP = 8'h41;  // 'A'
  localparam logic [7:0] CH_ARROW_DN = 8'h42;
  localparam logic [7:0] CH_ARROW_RT = 8'h43;
  localparam logic [7:0] CH_ARROW_LT = 8'h44;
  localparam logic [7:0] CH_SS3_P    = 8'h50;
  localparam logic [7:0] CH_SS3_Q    = 8'h51;
  localparam logic [7:0] CH_SS3_R    = 8'h52;
  localparam logic [7:0] CH_SS3_S    = 8'h53;
  localparam logic [7:0] CH_D0       = 8'h30;
  localparam logic [7:0] CH_D1       = 8'h31;
  localparam logic [7:0] CH_D2       = 8'h32;
  localparam logic [7:0] CH_D3       = 8'h33;
  localparam logic [7:0] CH_D4       = 8'h34;
  localparam logic [7:0] CH_D5       = 8'h35;
  localparam logic [7:0] CH_D6       = 8'h36;
  localparam logic [7:0] CH_D7       = 8'h37;
  localparam logic [7:0] CH_D8       = 8'h38;
  localparam logic [7:0] CH_D9       = 8'h39;
  localparam logic [7:0] FINAL_LO    = 8'h40;
  localparam logic [7:0] FINAL_HI    = 8'h7E;
  localparam logic [7:0] CTRL_OFS    = 8'h60;
  localparam logic [7:0] CTRL_A_LO   = 8'h01;
  localparam logic [7:0] CTRL_A_HI   = 8'h0C;
  localparam logic [7:0] CTRL_B_LO   = 8'h0E;
  localparam logic [7:0] CTRL_B_HI   = 8'h1A;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [4:0] key_code;
    logic [7:0] codepoint;
    logic       mod_shift;
    logic       mod_alt;
    logic       mod_ctrl;
    logic [2:0] mouse_button;
    logic [7:0] mouse_col;
    logic [7:0] mouse_row;
  } result_t;

  function automatic result_t key_result(logic [4:0] code, logic [7:0] cp,
                                         logic sh, logic al, logic ct);
    result_t r;
    r              = '0;
    r.event_kind   = EV_KEY;
    r.key_code     = code;
    r.codepoint    = cp;
    r.mod_shift    = sh;
    r.mod_alt      = al;
    r.mod_ctrl     = ct;
    return r;
  endfunction

  // 0 when not an arrow final
  function automatic logic [4:0] arrow_code(logic [7:0] b);
    logic [4:0] c;
    case (b)
      CH_ARROW_UP: c = KEY_UP;
      CH_ARROW_DN: c = KEY_DOWN;
      CH_ARROW_RT: c = KEY_RIGHT;
      CH_ARROW_LT: c = KEY_LEFT;
      default:     c = KEY_CHAR;
    endcase
    return c;
  endfunction

endpackage

/* hdl/tesd_parser.sv */
module tesd_parser #(
  parameter int MAX_SEQ = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic              seq_start,
  input  logic [7:0]        data_byte,
  output logic              emit,
  output tesd_pkg::result_t res
);
  import tesd_pkg::*;

  localparam int CNT_W = $clog2(MAX_SEQ + 1);

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       head_r [4];
  logic [7:0]       head_nxt [4];
  logic [7:0]       act_r, act_nxt;
  logic [7:0]       col_r, col_nxt;

  logic [CNT_W-1:0] len;
  logic             csi_end;
  logic             csi_hit;
  logic             csi_mouse;
  logic [4:0]       csi_key;
  logic [2:0]       csi_mods;
  logic [4:0]       arr_fin;
  logic [4:0]       arr_mod;
  logic             ctrl_rng;
  logic [2:0]       btn;

  // csi decode on the sequence as it stands after this byte
  always_comb begin
    len = cnt_r + CNT_W'(1);
    for (int i = 0; i < 4; i++) begin
      head_nxt[i] = (cnt_r == CNT_W'(i)) ? data_byte : head_r[i];
    end
    csi_end  = (data_byte >= FINAL_LO && data_byte <= FINAL_HI) ||
               (len >= CNT_W'(MAX_SEQ));
    arr_fin  = arrow_code(data_byte);
    arr_mod  = arrow_code(head_nxt[3]);
    csi_hit  = 1'b0;
    csi_key  = KEY_CHAR;
    csi_mods = 3'b000;
    if (len == CNT_W'(1) && arr_fin != KEY_CHAR) begin
      csi_hit = 1'b1;
      csi_key = arr_fin;
    end else if (len == CNT_W'(1) && data_byte == CH_HOME) begin
      csi_hit = 1'b1;
      csi_key = KEY_HOME;
    end else if (len == CNT_W'(1) && data_byte == CH_END) begin
      csi_hit = 1'b1;
      csi_key = KEY_END;
    end else if (data_byte == CH_TILDE && len == CNT_W'(2)) begin
      csi_hit = 1'b1;
      case (head_nxt[0])
        CH_D1:   csi_key = KEY_HOME;
        CH_D2:   csi_key = KEY_INSERT;
        CH_D3:   csi_key = KEY_DELETE;
        CH_D4:   csi_key = KEY_END;
        CH_D5:   csi_key = KEY_PGUP;
        CH_D6:   csi_key = KEY_PGDN;
        default: csi_hit = 1'b0;
      endcase
    end else if (data_byte == CH_TILDE && len == CNT_W'(3) && head_nxt[0] == CH_D1) begin
      csi_hit = 1'b1;
      case (head_nxt[1])
        CH_D1:   csi_key = KEY_F1;
        CH_D2:   csi_key = KEY_F2;
        CH_D3:   csi_key = KEY_F3;
        CH_D4:   csi_key = KEY_F4;
        CH_D5:   csi_key = KEY_F5;
        CH_D7:   csi_key = KEY_F6;
        CH_D8:   csi_key = KEY_F7;
        CH_D9:   csi_key = KEY_F8;
        default: csi_hit = 1'b0;
      endcase
    end else if (data_byte == CH_TILDE && len == CNT_W'(3) && head_nxt[0] == CH_D2) begin
      csi_hit = 1'b1;
      case (head_nxt[1])
        CH_D0:   csi_key = KEY_F9;
        CH_D1:   csi_key = KEY_F10;
        CH_D3:   csi_key = KEY_F11;
        CH_D4:   csi_key = KEY_F12;
        default: csi_hit = 1'b0;
      endcase
    end
    // modified arrows: 1;<m><arrow>
    if (!csi_hit && len == CNT_W'(4) && head_nxt[0] == CH_D1 &&
        head_nxt[1] == CH_SEMI && arr_mod != KEY_CHAR) begin
      csi_key = arr_mod;
      csi_hit = 1'b1;
      case (head_nxt[2])
        CH_D2:   csi_mods = 3'b100;
        CH_D3:   csi_mods = 3'b010;
        CH_D5:   csi_mods = 3'b001;
        default: csi_hit  = 1'b0;
      endcase
    end
    csi_mouse = !csi_hit && data_byte == CH_MOUSE;
  end

  assign ctrl_rng = (data_byte >= CTRL_A_LO && data_byte <= CTRL_A_HI) ||
                    (data_byte >= CTRL_B_LO && data_byte <= CTRL_B_HI);

  always_comb begin
    btn = {1'b0, act_r[1:0]};
    if (act_r[6]) begin
      case (act_r[1:0])
        2'd0:    btn = BTN_SCROLL_UP;
        2'd1:    btn = BTN_SCROLL_DN;
        default: btn = BTN_MOVE;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    act_nxt   = act_r;
    col_nxt   = col_r;
    if (take) begin
      if (seq_start) begin
        phase_nxt = PH_IDLE;
        if (data_byte == CH_CSI) begin
          phase_nxt = PH_CSI;
          cnt_nxt   = '0;
        end else if (data_byte == CH_SS3) begin
          phase_nxt = PH_SS3;
        end
      end else begin
        case (phase_r)
          PH_CSI: begin
            cnt_nxt = len;
            if (csi_end) begin
              phase_nxt = csi_mouse ? PH_MACT : PH_IDLE;
            end
          end
          PH_MACT: begin
            act_nxt   = data_byte;
            phase_nxt = PH_MCOL;
          end
          PH_MCOL: begin
            col_nxt   = data_byte;
            phase_nxt = PH_MROW;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // result
  always_comb begin
    emit = 1'b0;
    res  = '0;
    if (take) begin
      if (seq_start) begin
        if (data_byte != CH_CSI && data_byte != CH_SS3) begin
          emit = 1'b1;
          if (ctrl_rng) begin
            res = key_result(KEY_CHAR, data_byte + CTRL_OFS, 1'b0, 1'b1, 1'b1);
          end else begin
            res = key_result(KEY_CHAR, data_byte, 1'b0, 1'b1, 1'b0);
          end
        end
      end else begin
        case (phase_r)
          PH_CSI: begin
            if (csi_end && !csi_mouse) begin
              emit = 1'b1;
              if (csi_hit) begin
                res = key_result(csi_key, 8'h00, csi_mods[2], csi_mods[1], csi_mods[0]);
              end
            end
          end
          PH_SS3: begin
            emit = 1'b1;
            case (data_byte)
              CH_SS3_P: res = key_result(KEY_F1, 8'h00, 1'b0, 1'b0, 1'b0);
              CH_SS3_Q: res = key_result(KEY_F2, 8'h00, 1'b0, 1'b0, 1'b0);
              CH_SS3_R: res = key_result(KEY_F3, 8'h00, 1'b0, 1'b0, 1'b0);
              CH_SS3_S: res = key_result(KEY_F4, 8'h00, 1'b0, 1'b0, 1'b0);
              CH_HOME:  res = key_result(KEY_HOME, 8'h00, 1'b0, 1'b0, 1'b0);
              CH_END:   res = key_result(KEY_END, 8'h00, 1'b0, 1'b0, 1'b0);
              default:  res = '0;
            endcase
          end
          PH_MROW: begin
            emit             = 1'b1;
            res.event_kind   = EV_MOUSE;
            res.mod_shift    = act_r[2];
            res.mod_alt      = act_r[3];
            res.mod_ctrl     = act_r[4];
            res.mouse_button = btn;
            res.mouse_col    = col_r;
            res.mouse_row    = data_byte;
          end
          default: emit = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      act_r   <= '0;
      col_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      act_r   <= act_nxt;
      col_r   <= col_nxt;
    end
  end

  // only the first four csi bytes are kept; no reset needed
  always_ff @(posedge clk) begin
    if (take && !seq_start && phase_r == PH_CSI && cnt_r < CNT_W'(4)) begin
      head_r <= head_nxt;
    end
  end

endmodule

/* hdl/terminal_escape_sequence_decoder_core.sv */
// channel | direction | ports
// in      | input     | in_valid, in_stall, in_seq_start, in_data_byte
// out     | output    | out_valid, out_stall, out_event_kind .. out_mouse_row
//
// one byte per cycle sustained while out_stall is low; a byte is registered in the
// input register, is decoded there and any event lands in the result register
// synchronous active-low reset clears the sequence phase and both valid flags
// a stalled result holds; the input register keeps taking bytes as long as it is
// empty or the result register is empty or being drained in the same cycle
module terminal_escape_sequence_decoder_core #(
  parameter int MAX_SEQ = 32  // csi length limit, 4..63
) (
  input  logic       clk,
  input  logic       rst_n,
  // input beats
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_seq_start,
  input  logic [7:0] in_data_byte,
  // result beats
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_kind,
  output logic [4:0] out_key_code,
  output logic [7:0] out_codepoint,
  output logic       out_mod_shift,
  output logic       out_mod_alt,
  output logic       out_mod_ctrl,
  output logic [2:0] out_mouse_button,
  output logic [7:0] out_mouse_col,
  output logic [7:0] out_mouse_row
);
  import tesd_pkg::*;

  // input register
  logic       in_v_r, in_v_nxt;
  logic       start_r;
  logic [7:0] byte_r;

  // result register
  logic       out_v_r, out_v_nxt;
  result_t    res_r;

  logic       adv;      // input register may move on this cycle
  logic       take;     // byte in input register is decoded now
  logic       in_acc;   // new input beat
  logic       emit;
  result_t    res;

  // result register is free when empty or its beat leaves this cycle
  assign adv      = !out_v_r || !out_stall;
  assign take     = in_v_r && adv;
  assign in_stall = in_v_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  tesd_parser #(
    .MAX_SEQ (MAX_SEQ)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .seq_start (start_r),
    .data_byte (byte_r),
    .emit      (emit),
    .res       (res)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_acc) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (take && emit) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payloads, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      start_r <= in_seq_start;
      byte_r  <= in_data_byte;
    end
    if (take && emit) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_event_kind   = res_r.event_kind;
  assign out_key_code     = res_r.key_code;
  assign out_codepoint    = res_r.codepoint;
  assign out_mod_shift    = res_r.mod_shift;
  assign out_mod_alt      = res_r.mod_alt;
  assign out_mod_ctrl     = res_r.mod_ctrl;
  assign out_mouse_button = res_r.mouse_button;
  assign out_mouse_col    = res_r.mouse_col;
  assign out_mouse_row    = res_r.mouse_row;

endmodule
